[rtl/core/ahfp_pkg.sv]
// ----------------------------------------------------------------------------
// ahfp_pkg
// Shared types, constants and the hex digit decoder for the ASCII-hex frame
// parser core.
// ----------------------------------------------------------------------------
package ahfp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned IndexW = 12;
	localparam int unsigned WordW  = 16;

	localparam logic [IndexW-1:0] InfoCountMask = 12'hFFF;

	localparam logic [CharW-1:0] DigitLo  = 8'h30;
	localparam logic [CharW-1:0] DigitHi  = 8'h39;
	localparam logic [CharW-1:0] UpperLo  = 8'h41;
	localparam logic [CharW-1:0] UpperHi  = 8'h46;
	localparam logic [CharW-1:0] LowerLo  = 8'h61;
	localparam logic [CharW-1:0] LowerHi  = 8'h66;
	localparam logic [CharW-1:0] UpperOff = 8'h37;
	localparam logic [CharW-1:0] LowerOff = 8'h57;

	localparam logic RESULT_INFO  = 1'b0;
	localparam logic RESULT_FRAME = 1'b1;

	// Parser phases, one-hot.
	typedef enum logic [8:0] {
		PH_IDLE = 9'b0_0000_0001,
		PH_VER  = 9'b0_0000_0010,
		PH_ADR  = 9'b0_0000_0100,
		PH_CID1 = 9'b0_0000_1000,
		PH_CID2 = 9'b0_0001_0000,
		PH_LEN  = 9'b0_0010_0000,
		PH_INFO = 9'b0_0100_0000,
		PH_CHK  = 9'b0_1000_0000,
		PH_END  = 9'b1_0000_0000
	} phase_t;

	typedef struct packed {
		logic              result_kind;
		logic [CharW-1:0]  start_byte;
		logic [CharW-1:0]  version;
		logic [CharW-1:0]  station_addr;
		logic [CharW-1:0]  cid_one;
		logic [CharW-1:0]  cid_two;
		logic [WordW-1:0]  length_word;
		logic [IndexW-1:0] info_index;
		logic [CharW-1:0]  info_byte;
		logic [WordW-1:0]  check_word;
		logic [CharW-1:0]  end_byte;
	} result_t;

	// Parser status seen by the top level.
	typedef struct packed {
		phase_t     phase;
		logic [1:0] char_count;
	} parse_stat_t;

	// Characters that are not hex digits decode as zero.
	function automatic logic [3:0] hex_nibble(input logic [CharW-1:0] c);
		logic [CharW-1:0] diff;
		diff = '0;
		if (c >= DigitLo && c <= DigitHi) begin
			diff = c - DigitLo;
		end else if (c >= UpperLo && c <= UpperHi) begin
			diff = c - UpperOff;
		end else if (c >= LowerLo && c <= LowerHi) begin
			diff = c - LowerOff;
		end
		return diff[3:0];
	endfunction

endpackage

[rtl/core/ahfp_parser.sv]
// ----------------------------------------------------------------------------
// ahfp_parser
// Frame parsing state: phase, nibble collection, header registers and the
// INFO counter. Produces at most one result per consumed character.
// ----------------------------------------------------------------------------
module ahfp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [ahfp_pkg::CharW-1:0]  char_in,
	input  logic                        frame_first,
	output logic                        res_valid,
	output ahfp_pkg::result_t           res,
	output ahfp_pkg::parse_stat_t       stat
);
	import ahfp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [1:0]         count_q, count_d;
	logic [11:0]        shift_q, shift_d;
	logic [CharW-1:0]   start_q, start_d;
	logic [CharW-1:0]   ver_q, ver_d;
	logic [CharW-1:0]   adr_q, adr_d;
	logic [CharW-1:0]   cid1_q, cid1_d;
	logic [CharW-1:0]   cid2_q, cid2_d;
	logic [WordW-1:0]   len_q, len_d;
	logic [IndexW-1:0]  idx_q, idx_d;
	logic [WordW-1:0]   chk_q, chk_d;
	logic [3:0]         nib;
	logic [CharW-1:0]   pair;
	logic [WordW-1:0]   word;
	logic [IndexW-1:0]  idx_inc;

	assign nib     = hex_nibble(char_in);
	assign pair    = {shift_q[3:0], nib};
	assign word    = {shift_q, nib};
	assign idx_inc = idx_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		shift_d   = shift_q;
		start_d   = start_q;
		ver_d     = ver_q;
		adr_d     = adr_q;
		cid1_d    = cid1_q;
		cid2_d    = cid2_q;
		len_d     = len_q;
		idx_d     = idx_q;
		chk_d     = chk_q;
		res_valid = 1'b0;

		res              = '0;
		res.start_byte   = start_q;
		res.version      = ver_q;
		res.station_addr = adr_q;
		res.cid_one      = cid1_q;
		res.cid_two      = cid2_q;
		res.length_word  = len_q;

		if (frame_first) begin
			start_d = char_in;
			count_d = '0;
			shift_d = '0;
			idx_d   = '0;
			phase_d = PH_VER;
		end else begin
			unique case (phase_q)
				PH_VER, PH_ADR, PH_CID1, PH_CID2, PH_INFO: begin
					if (count_q == 2'd0) begin
						shift_d = {8'h00, nib};
						count_d = 2'd1;
					end else begin
						count_d = '0;
						shift_d = '0;
						unique case (phase_q)
							PH_VER: begin
								ver_d   = pair;
								phase_d = PH_ADR;
							end
							PH_ADR: begin
								adr_d   = pair;
								phase_d = PH_CID1;
							end
							PH_CID1: begin
								cid1_d  = pair;
								phase_d = PH_CID2;
							end
							PH_CID2: begin
								cid2_d  = pair;
								phase_d = PH_LEN;
							end
							default: begin
								res_valid      = 1'b1;
								res.result_kind = RESULT_INFO;
								res.info_index = idx_q;
								res.info_byte  = pair;
								idx_d          = idx_inc;
								if (idx_inc == (len_q[IndexW-1:0] & InfoCountMask)) begin
									phase_d = PH_CHK;
								end
							end
						endcase
					end
				end
				PH_LEN, PH_CHK: begin
					if (count_q != 2'd3) begin
						shift_d = {shift_q[7:0], nib};
						count_d = count_q + 2'd1;
					end else begin
						count_d = '0;
						shift_d = '0;
						if (phase_q == PH_LEN) begin
							len_d   = word;
							idx_d   = '0;
							phase_d = ((word[IndexW-1:0] & InfoCountMask) != '0) ?
								PH_INFO : PH_CHK;
						end else begin
							chk_d   = word;
							phase_d = PH_END;
						end
					end
				end
				PH_END: begin
					res_valid       = 1'b1;
					res.result_kind = RESULT_FRAME;
					res.check_word  = chk_q;
					res.end_byte    = char_in;
					phase_d         = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (!step) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			shift_q <= '0;
			start_q <= '0;
			ver_q   <= '0;
			adr_q   <= '0;
			cid1_q  <= '0;
			cid2_q  <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			chk_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			start_q <= start_d;
			ver_q   <= ver_d;
			adr_q   <= adr_d;
			cid1_q  <= cid1_d;
			cid2_q  <= cid2_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			chk_q   <= chk_d;
		end
	end

	assign stat.phase      = phase_q;
	assign stat.char_count = count_q;

endmodule

[rtl/core/ahfp_out_stage.sv]
// ----------------------------------------------------------------------------
// ahfp_out_stage
// Result register of the parser; holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module ahfp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ahfp_pkg::result_t load_data,
	output logic              can_load,
	output logic              tvalid,
	input  logic              tready,
	output ahfp_pkg::result_t data
);
	import ahfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	// The register frees up in the same cycle its content is taken.
	assign can_load = !valid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

	assign tvalid = valid_q;
	assign data   = data_q;

endmodule

[rtl/core/ascii_hex_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// ascii_hex_frame_parser_core
// Deframer for ASCII-hex serial frames: start byte, hex header, INFO bytes,
// hex checksum and end byte. Emits one result per INFO byte and one per frame.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata                           tuser
// s_*       in   char_in[7:0]                    frame_first
// m_*       out  header, INFO and check fields   result_kind
//
// Each received character moves through two registers: the input register
// (_s1) and the result register. One character can be taken every cycle
// while the sink keeps up. A result shows up on m_* from the result register,
// after the character that causes it has passed the input register.
// The parser state advances only when the result register can take what
// the character produces, so a stalled sink holds the input register and
// deasserts s_tready. Reset clears the parser to idle and empties both
// registers; characters before the first start flag produce no result.
//
module ascii_hex_frame_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_in
	input  logic         s_tuser,   // [0] frame_first
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] start_byte, [15:8] version, [23:16] station_addr, [31:24] cid_one,
	// [39:32] cid_two, [55:40] length_word, [67:56] info_index,
	// [75:68] info_byte, [91:76] check_word, [99:92] end_byte, [103:100] zero
	output logic [103:0] m_tdata,
	output logic         m_tuser    // [0] result_kind
);
	import ahfp_pkg::*;

	logic              valid_s1;
	logic [CharW-1:0]  char_s1;
	logic              first_s1;
	logic              advance;
	logic              can_load;
	logic              res_valid;
	result_t           res;
	result_t           out_data;
	parse_stat_t       stat;

	// The character in the input register is consumed once the result
	// register has room for whatever it produces.
	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	ahfp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.char_in     (char_s1),
		.frame_first (first_s1),
		.res_valid   (res_valid),
		.res         (res),
		.stat        (stat)
	);

	ahfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_data (res),
		.can_load  (can_load),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.data      (out_data)
	);

	assign m_tuser = out_data.result_kind;
	assign m_tdata = {4'b0000, out_data.end_byte, out_data.check_word,
		out_data.info_byte, out_data.info_index, out_data.length_word,
		out_data.cid_two, out_data.cid_one, out_data.station_addr,
		out_data.version, out_data.start_byte};

	// An accepted character always lands in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted character missing from input register");

	// Results come only from INFO pairs or the end byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (stat.phase == PH_INFO || stat.phase == PH_END))
		else $error("result produced outside INFO or end phase");

	// A closing result returns the parser to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == RESULT_FRAME |=> stat.phase == PH_IDLE)
		else $error("parser not idle after frame end");

	// A produced result is held in the result register on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("result lost before output register");

endmodule
